FILE: sv/rv32ic_instruction_decoder_core_assert.svh
// Assertion macros used by the checker file
`ifndef RV32IC_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define RV32IC_INSTRUCTION_DECODER_CORE_ASSERT_SVH
// Assert that a condition implies a property on the same edge
`define RVD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");
// Assert that a condition implies a property on the next edge
`define RVD_ASSERT_NXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");
`endif

FILE: sv/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared types and constants of the RV32IC instruction decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rvd_pkg;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_ILLEGAL  = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  // Class codes
  localparam logic [5:0] CL_OP = 6'd0,  CL_OPIMM = 6'd1, CL_LOAD = 6'd2, CL_JALR = 6'd3;
  localparam logic [5:0] CL_STORE = 6'd4, CL_JAL = 6'd5, CL_BRANCH = 6'd6, CL_SYSTEM = 6'd7;
  localparam logic [5:0] CL_C_ADDI4SPN = 6'd8,  CL_C_FLD = 6'd9,   CL_C_LW = 6'd10;
  localparam logic [5:0] CL_C_FLW = 6'd11,      CL_C_FSD = 6'd12,  CL_C_SW = 6'd13;
  localparam logic [5:0] CL_C_FSW = 6'd14,      CL_C_NOP = 6'd15,  CL_C_ADDI = 6'd16;
  localparam logic [5:0] CL_C_JAL = 6'd17,      CL_C_LI = 6'd18,   CL_C_ADDI16SP = 6'd19;
  localparam logic [5:0] CL_C_LUI = 6'd20,      CL_C_SRLI = 6'd21, CL_C_ANDI = 6'd23;
  localparam logic [5:0] CL_C_SUB = 6'd24,      CL_C_J = 6'd28,    CL_C_BEQZ = 6'd29;
  localparam logic [5:0] CL_C_BNEZ = 6'd30,     CL_C_SLLI = 6'd31, CL_C_FLDSP = 6'd32;
  localparam logic [5:0] CL_C_LWSP = 6'd33,     CL_C_FLWSP = 6'd34, CL_C_JR = 6'd35;
  localparam logic [5:0] CL_C_MV = 6'd36,       CL_C_EBREAK = 6'd37, CL_C_JALR = 6'd38;
  localparam logic [5:0] CL_C_ADD = 6'd39,      CL_C_FSDSP = 6'd40, CL_C_SWSP = 6'd41;
  localparam logic [5:0] CL_C_FSWSP = 6'd42,    CL_NONE = 6'd63;

  // Major opcodes
  localparam logic [6:0] OPC_OP = 7'd51, OPC_OPIMM = 7'd19, OPC_LOAD = 7'd3;
  localparam logic [6:0] OPC_JALR = 7'd103, OPC_STORE = 7'd35, OPC_JAL = 7'd111;
  localparam logic [6:0] OPC_BRANCH = 7'd99, OPC_SYSTEM = 7'd115;

  // Decoded fields of one instruction
  typedef struct packed {
    logic [5:0]  op_class;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [20:0] immediate;
    logic [2:0]  funct3_field;
    logic [6:0]  funct7_field;
    logic [1:0]  status;
    logic        has_target;
  } dec_t;

  // Queue entry from front to back
  typedef struct packed {
    logic [31:0] inst_bits;
    logic        compressed;
    dec_t        dec;
  } item_t;

  // Zeroed decode record for error status
  function automatic dec_t dec_err(input logic [1:0] st);
    dec_t d;
    d = '0;
    d.op_class = CL_NONE;
    d.status = st;
    return d;
  endfunction

  function automatic dec_t decode32(input logic [31:0] w);
    dec_t d;
    logic [20:0] i12;
    d = '0;
    i12 = {{9{w[31]}}, w[31:20]};
    d.funct3_field = w[14:12];
    unique case (w[6:0])
      OPC_OP: begin
        d.op_class = CL_OP; d.dest_reg = w[11:7]; d.src1_reg = w[19:15];
        d.src2_reg = w[24:20]; d.funct7_field = w[31:25];
      end
      OPC_OPIMM: begin
        d.op_class = CL_OPIMM; d.dest_reg = w[11:7]; d.src1_reg = w[19:15];
        if (w[13:12] == 2'b01) begin
          d.immediate = {16'd0, w[24:20]}; d.funct7_field = w[31:25];
        end else begin
          d.immediate = i12;
        end
      end
      OPC_LOAD, OPC_JALR: begin
        d.op_class = (w[6:0] == OPC_LOAD) ? CL_LOAD : CL_JALR;
        d.dest_reg = w[11:7]; d.src1_reg = w[19:15]; d.immediate = i12;
      end
      OPC_STORE: begin
        d.op_class = CL_STORE; d.src1_reg = w[19:15]; d.src2_reg = w[24:20];
        d.immediate = {{9{w[31]}}, w[31:25], w[11:7]};
      end
      OPC_JAL: begin
        d.op_class = CL_JAL; d.dest_reg = w[11:7]; d.has_target = 1'b1;
        d.funct3_field = 3'd0;
        d.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_BRANCH: begin
        d.op_class = CL_BRANCH; d.src1_reg = w[19:15]; d.src2_reg = w[24:20];
        d.has_target = 1'b1;
        d.immediate = {{8{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_SYSTEM: begin
        d.op_class = CL_SYSTEM; d.dest_reg = w[11:7]; d.src1_reg = w[19:15];
        d.immediate = {9'd0, w[31:20]};
      end
      default: d = dec_err(ST_UNKNOWN);
    endcase
    return d;
  endfunction

  function automatic dec_t decode16(input logic [15:0] h);
    dec_t d;
    logic [4:0] rpl, rph, rhi, rlo;
    logic [20:0] i6;
    logic [9:0] nz;
    d = '0;
    rpl = {2'b01, h[4:2]};
    rph = {2'b01, h[9:7]};
    rhi = h[11:7];
    rlo = h[6:2];
    i6 = {{16{h[12]}}, h[6:2]};
    nz = {h[12], h[4:3], h[5], h[2], h[6], 4'd0};
    d.funct3_field = h[15:13];
    if (h == 16'd0) begin
      d = dec_err(ST_ILLEGAL);
    end else begin
      unique case (h[1:0])
        2'd0: begin
          unique case (h[15:13])
            3'd0: begin
              d.op_class = CL_C_ADDI4SPN; d.dest_reg = rpl; d.src1_reg = 5'd2;
              d.immediate = {11'd0, h[10:7], h[12:11], h[5], h[6], 2'd0};
              if (h[12:5] == 8'd0) d = dec_err(ST_RESERVED);
            end
            3'd4: d = dec_err(ST_RESERVED);
            default: begin
              unique case (h[15:13])
                3'd1: d.op_class = CL_C_FLD;
                3'd2: d.op_class = CL_C_LW;
                3'd3: d.op_class = CL_C_FLW;
                3'd5: d.op_class = CL_C_FSD;
                3'd6: d.op_class = CL_C_SW;
                default: d.op_class = CL_C_FSW;
              endcase
              d.src1_reg = rph;
              // Double-word forms scale the offset by eight
              if (h[14:13] == 2'b01) d.immediate = {13'd0, h[6:5], h[12:10], 3'd0};
              else d.immediate = {14'd0, h[5], h[12:10], h[6], 2'd0};
              if (h[15]) d.src2_reg = rpl; else d.dest_reg = rpl;
            end
          endcase
        end
        2'd1: begin
          unique case (h[15:13])
            3'd0: begin
              if (h[12:2] == 11'd0) begin
                d.op_class = CL_C_NOP;
              end else begin
                d.op_class = CL_C_ADDI; d.dest_reg = rhi; d.src1_reg = rhi;
                d.immediate = i6;
              end
            end
            3'd1, 3'd5: begin
              d.op_class = h[15] ? CL_C_J : CL_C_JAL;
              d.dest_reg = h[15] ? 5'd0 : 5'd1; d.has_target = 1'b1;
              d.immediate = {{9{h[12]}}, h[12], h[8], h[10:9], h[6], h[7], h[2],
                             h[11], h[5:3], 1'b0};
            end
            3'd2: begin
              d.op_class = CL_C_LI; d.dest_reg = rhi; d.immediate = i6;
            end
            3'd3: begin
              if (rhi == 5'd2) begin
                d.op_class = CL_C_ADDI16SP; d.dest_reg = 5'd2; d.src1_reg = 5'd2;
                d.immediate = {{11{nz[9]}}, nz};
                if (nz == 10'd0) d = dec_err(ST_RESERVED);
              end else begin
                d.op_class = CL_C_LUI; d.dest_reg = rhi;
                d.immediate = {{3{h[12]}}, h[12], rlo, 12'd0};
                if ({h[12], rlo} == 6'd0) d = dec_err(ST_RESERVED);
              end
            end
            3'd4: begin
              d.dest_reg = rph; d.src1_reg = rph;
              if (h[11:10] == 2'd2) begin
                d.op_class = CL_C_ANDI; d.immediate = i6;
              end else if (h[12]) begin
                d = dec_err(ST_RESERVED);
              end else if (h[11:10] == 2'd3) begin
                d.op_class = CL_C_SUB + {4'd0, h[6:5]}; d.src2_reg = rpl;
              end else begin
                d.op_class = CL_C_SRLI + {5'd0, h[10]};
                d.immediate = {16'd0, rlo};
              end
            end
            default: begin
              d.op_class = h[13] ? CL_C_BNEZ : CL_C_BEQZ; d.src1_reg = rph;
              d.has_target = 1'b1;
              d.immediate = {{12{h[12]}}, h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0};
            end
          endcase
        end
        2'd2: begin
          unique case (h[15:13])
            3'd0: begin
              d.op_class = CL_C_SLLI; d.dest_reg = rhi; d.src1_reg = rhi;
              d.immediate = {16'd0, rlo};
              if (h[12]) d = dec_err(ST_RESERVED);
            end
            3'd1: begin
              d.op_class = CL_C_FLDSP; d.dest_reg = rhi; d.src1_reg = 5'd2;
              d.immediate = {12'd0, h[4:2], h[12], h[6:5], 3'd0};
            end
            3'd2, 3'd3: begin
              d.op_class = h[13] ? CL_C_FLWSP : CL_C_LWSP; d.dest_reg = rhi;
              d.src1_reg = 5'd2;
              d.immediate = {13'd0, h[3:2], h[12], h[6:4], 2'd0};
              if (!h[13] && rhi == 5'd0) d = dec_err(ST_RESERVED);
            end
            3'd4: begin
              if (rlo == 5'd0) begin
                if (!h[12]) begin
                  d.op_class = CL_C_JR; d.src1_reg = rhi;
                  if (rhi == 5'd0) d = dec_err(ST_RESERVED);
                end else if (rhi == 5'd0) begin
                  d.op_class = CL_C_EBREAK;
                end else begin
                  d.op_class = CL_C_JALR; d.dest_reg = 5'd1; d.src1_reg = rhi;
                end
              end else if (!h[12]) begin
                d.op_class = CL_C_MV; d.dest_reg = rhi; d.src2_reg = rlo;
              end else begin
                d.op_class = CL_C_ADD; d.dest_reg = rhi; d.src1_reg = rhi;
                d.src2_reg = rlo;
              end
            end
            3'd5: begin
              d.op_class = CL_C_FSDSP; d.src1_reg = 5'd2; d.src2_reg = rlo;
              d.immediate = {12'd0, h[9:7], h[12:10], 3'd0};
            end
            default: begin
              d.op_class = h[13] ? CL_C_FSWSP : CL_C_SWSP; d.src1_reg = 5'd2;
              d.src2_reg = rlo;
              d.immediate = {13'd0, h[8:7], h[12:9], 2'd0};
            end
          endcase
        end
        default: d = dec_err(ST_UNKNOWN);
      endcase
    end
    return d;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rv32ic_instruction_decoder_core.sv
// ----------------------------------------------------------------------------
// rv32ic_instruction_decoder_core
// RV32IC decoder taking 16-bit parcels and giving one decoded word per instruction.
// ----------------------------------------------------------------------------
// One parcel is taken per cycle. A compressed parcel passes through the queue to
// the output; a parcel with low bits 11 is held and the next completes the 32-bit
// instruction. The front decodes combinationally into a two-entry queue; the
// back adds the running address and branch target into the output register.
// Throughput is one parcel per cycle, limited only by the output handshake.
`timescale 1ns / 1ps
`default_nettype none
module rv32ic_instruction_decoder_core #(
  parameter int PC_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // parcel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // inst_pc, inst_bits, compressed, op_class, dest_reg, src1_reg, src2_reg,
  // immediate, target, funct3_field, funct7_field, status, one zero bit
  output logic [151:0]      out_tdata
);
  import rvd_pkg::*;

  logic        f_valid, f_ready, b_valid, b_ready;
  item_t       f_item, b_item, o_item;
  logic [31:0] o_pc, o_target;

  rvd_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .parcel(in_tdata),
    .item_valid(f_valid), .item(f_item), .item_ready(f_ready)
  );

  rvd_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_item(f_item), .wr_ready(f_ready),
    .rd_valid(b_valid), .rd_item(b_item), .rd_ready(b_ready)
  );

  rvd_back #(.PC_BITS(PC_BITS)) u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_item(b_item), .q_ready(b_ready),
    .out_valid(out_tvalid), .out_ready(out_tready), .o_pc, .o_target, .o_item
  );

  // Pack the result word
  assign out_tdata = {1'b0, o_item.dec.status, o_item.dec.funct7_field,
                      o_item.dec.funct3_field, o_target, o_item.dec.immediate,
                      o_item.dec.src2_reg, o_item.dec.src1_reg, o_item.dec.dest_reg,
                      o_item.dec.op_class, o_item.compressed, o_item.inst_bits, o_pc};

endmodule
`default_nettype wire

FILE: sv/rvd_front.sv
// ----------------------------------------------------------------------------
// rvd_front
// Pairs parcels into instructions and classifies them into a decode record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rvd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [15:0]    parcel,
  output logic                item_valid,
  output rvd_pkg::item_t      item,
  input  wire logic           item_ready
);
  import rvd_pkg::*;

  logic        pend_r, pend_nxt;
  logic [15:0] held_r, held_nxt;
  logic        take;
  logic        upper;

  // Accept whenever the queue has room for a possible result
  assign in_ready = item_ready;
  assign take     = in_valid && in_ready;
  assign upper    = pend_r;

  // Form the item
  always_comb begin
    item = '0;
    if (upper) begin
      item.inst_bits  = {parcel, held_r};
      item.compressed = 1'b0;
      item.dec        = decode32({parcel, held_r});
    end else begin
      item.inst_bits  = {16'd0, parcel};
      item.compressed = 1'b1;
      item.dec        = decode16(parcel);
    end
  end
  assign item_valid = take && (upper || parcel[1:0] != 2'b11);

  // Track the held low half
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (take) begin
      if (upper) begin
        pend_nxt = 1'b0;
      end else if (parcel[1:0] == 2'b11) begin
        pend_nxt = 1'b1;
        held_nxt = parcel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rvd_queue.sv
// ----------------------------------------------------------------------------
// rvd_queue
// Two-entry queue between the front and back halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rvd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  input  rvd_pkg::item_t      wr_item,
  output logic                wr_ready,
  output logic                rd_valid,
  output rvd_pkg::item_t      rd_item,
  input  wire logic           rd_ready
);
  import rvd_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

endmodule
`default_nettype wire

FILE: sv/rvd_back.sv
// ----------------------------------------------------------------------------
// rvd_back
// Stamps each instruction with its address and target into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module rvd_back #(
  parameter int PC_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  rvd_pkg::item_t      q_item,
  output logic                q_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [31:0]         o_pc,
  output logic [31:0]         o_target,
  output rvd_pkg::item_t      o_item
);
  import rvd_pkg::*;

  logic [PC_BITS-1:0] pc_r, pc_nxt, tgt;
  logic               vld_r, vld_nxt;
  logic [31:0]        opc_r, tgt_r;
  item_t              item_r;
  logic               load;

  assign q_ready = !vld_r || out_ready;
  assign load    = q_valid && q_ready;
  assign tgt     = pc_r + PC_BITS'({{(PC_BITS > 21 ? PC_BITS - 21 : 1){q_item.dec.immediate[20]}},
                                    q_item.dec.immediate});

  // Advance the address and output valid
  always_comb begin
    pc_nxt  = pc_r;
    vld_nxt = vld_r && !out_ready;
    if (load) begin
      pc_nxt  = pc_r + (q_item.compressed ? PC_BITS'(2) : PC_BITS'(4));
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= '0;
      vld_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Hold the result word
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= q_item;
      opc_r  <= 32'(pc_r);
      tgt_r  <= q_item.dec.has_target ? 32'(tgt) : 32'd0;
    end
  end

  assign out_valid = vld_r;
  assign o_pc      = opc_r;
  assign o_target  = tgt_r;
  assign o_item    = item_r;

endmodule
`default_nettype wire

FILE: sv/rvd_checker.sv
// ----------------------------------------------------------------------------
// rvd_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "rv32ic_instruction_decoder_core_assert.svh"
module rvd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [151:0] out_tdata
);
  // Stalled result holds
  `RVD_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // Error status carries the no-class code
  `RVD_ASSERT_IMP(a_cls, clk, rst_n, out_tvalid && out_tdata[150:149] != 2'd0,
                  out_tdata[70:65] == 6'd63)
  // Compressed words have a zero upper half
  `RVD_ASSERT_IMP(a_comp, clk, rst_n, out_tvalid && out_tdata[64],
                  out_tdata[63:48] == 16'd0)
  // Address is even
  `RVD_ASSERT_IMP(a_even, clk, rst_n, out_tvalid, !out_tdata[0])
endmodule

bind rv32ic_instruction_decoder_core rvd_checker u_rvd_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// RV32IC decoder testbench
// Streams 16-bit parcels into the decoder and checks every decoded word
// against a behavioural decode kept alongside, under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Fields from the highest bit down, matching the packed result word
typedef struct packed {
  logic [1:0]  status;
  logic [6:0]  funct7_field;
  logic [2:0]  funct3_field;
  logic [31:0] target;
  logic [20:0] immediate;
  logic [4:0]  src2_reg;
  logic [4:0]  src1_reg;
  logic [4:0]  dest_reg;
  logic [5:0]  op_class;
  logic        compressed;
  logic [31:0] inst_bits;
  logic [31:0] inst_pc;
} decoded_word_t;

class decode_scoreboard;
  decoded_word_t pending_words[$];
  logic [15:0]   low_half;
  bit            half_held;
  logic [31:0]   pc;
  int            failures;

  function new();
    half_held = 0;
    low_half = '0;
    pc = '0;
    failures = 0;
  endfunction

  // Decode one complete compressed or full-width instruction
  function automatic decoded_word_t decode_word(logic [31:0] w, bit comp);
    decoded_word_t r;
    logic [15:0] h;
    logic [4:0] rpl, rph, rhi, rlo;
    logic [20:0] i6, v;
    logic [9:0] nz;
    bit tgt;
    r = '0;
    tgt = 0;
    h = w[15:0];
    rpl = {2'b01, h[4:2]};
    rph = {2'b01, h[9:7]};
    rhi = h[11:7];
    rlo = h[6:2];
    i6 = {{16{h[12]}}, h[6:2]};
    r.inst_bits = w;
    r.compressed = comp;
    r.inst_pc = pc;
    if (!comp) begin
      r.funct3_field = w[14:12];
      case (w[6:0])
        rvd_pkg::OPC_OP: begin
          r.op_class = rvd_pkg::CL_OP; r.dest_reg = w[11:7]; r.src1_reg = w[19:15];
          r.src2_reg = w[24:20]; r.funct7_field = w[31:25];
        end
        rvd_pkg::OPC_OPIMM: begin
          r.op_class = rvd_pkg::CL_OPIMM; r.dest_reg = w[11:7]; r.src1_reg = w[19:15];
          if (w[14:12] == 3'd1 || w[14:12] == 3'd5) begin
            r.immediate = {16'd0, w[24:20]}; r.funct7_field = w[31:25];
          end else r.immediate = 21'($signed(w[31:20]));
        end
        rvd_pkg::OPC_LOAD, rvd_pkg::OPC_JALR: begin
          r.op_class = (w[6:0] == rvd_pkg::OPC_LOAD) ? rvd_pkg::CL_LOAD : rvd_pkg::CL_JALR;
          r.dest_reg = w[11:7]; r.src1_reg = w[19:15];
          r.immediate = 21'($signed(w[31:20]));
        end
        rvd_pkg::OPC_STORE: begin
          r.op_class = rvd_pkg::CL_STORE; r.src1_reg = w[19:15]; r.src2_reg = w[24:20];
          r.immediate = 21'($signed({w[31:25], w[11:7]}));
        end
        rvd_pkg::OPC_JAL: begin
          r.op_class = rvd_pkg::CL_JAL; r.dest_reg = w[11:7]; tgt = 1;
          r.funct3_field = 3'd0;
          r.immediate = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        rvd_pkg::OPC_BRANCH: begin
          r.op_class = rvd_pkg::CL_BRANCH; r.src1_reg = w[19:15]; r.src2_reg = w[24:20];
          tgt = 1;
          r.immediate = 21'($signed({w[31], w[7], w[30:25], w[11:8], 1'b0}));
        end
        rvd_pkg::OPC_SYSTEM: begin
          r.op_class = rvd_pkg::CL_SYSTEM; r.dest_reg = w[11:7]; r.src1_reg = w[19:15];
          r.immediate = {9'd0, w[31:20]};
        end
        default: r.status = rvd_pkg::ST_UNKNOWN;
      endcase
    end else begin
      r.funct3_field = h[15:13];
      if (h == 16'd0) r.status = rvd_pkg::ST_ILLEGAL;
      else if (h[1:0] == 2'd0) begin
        case (h[15:13])
          3'd0: begin
            v = {11'd0, h[10:7], h[12:11], h[5], h[6], 2'b00};
            if (v == 21'd0) r.status = rvd_pkg::ST_RESERVED;
            r.op_class = rvd_pkg::CL_C_ADDI4SPN; r.dest_reg = rpl; r.src1_reg = 5'd2;
            r.immediate = v;
          end
          3'd4: r.status = rvd_pkg::ST_RESERVED;
          default: begin
            case (h[15:13])
              3'd1: r.op_class = rvd_pkg::CL_C_FLD;
              3'd2: r.op_class = rvd_pkg::CL_C_LW;
              3'd3: r.op_class = rvd_pkg::CL_C_FLW;
              3'd5: r.op_class = rvd_pkg::CL_C_FSD;
              3'd6: r.op_class = rvd_pkg::CL_C_SW;
              default: r.op_class = rvd_pkg::CL_C_FSW;
            endcase
            r.src1_reg = rph;
            if (h[15:13] == 3'd1 || h[15:13] == 3'd5)
              r.immediate = {13'd0, h[6:5], h[12:10], 3'b000};
            else r.immediate = {14'd0, h[5], h[12:10], h[6], 2'b00};
            if (h[15]) r.src2_reg = rpl; else r.dest_reg = rpl;
          end
        endcase
      end else if (h[1:0] == 2'd1) begin
        case (h[15:13])
          3'd0:
            if (h[12:2] == 11'd0) r.op_class = rvd_pkg::CL_C_NOP;
            else begin
              r.op_class = rvd_pkg::CL_C_ADDI; r.dest_reg = rhi; r.src1_reg = rhi;
              r.immediate = i6;
            end
          3'd1, 3'd5: begin
            r.op_class = h[15] ? rvd_pkg::CL_C_J : rvd_pkg::CL_C_JAL;
            r.dest_reg = h[15] ? 5'd0 : 5'd1; tgt = 1;
            r.immediate = 21'($signed({h[12], h[8], h[10:9], h[6], h[7], h[2], h[11],
                                       h[5:3], 1'b0}));
          end
          3'd2: begin
            r.op_class = rvd_pkg::CL_C_LI; r.dest_reg = rhi; r.immediate = i6;
          end
          3'd3:
            if (rhi == 5'd2) begin
              nz = {h[12], h[4:3], h[5], h[2], h[6], 4'd0};
              if (nz == 10'd0) r.status = rvd_pkg::ST_RESERVED;
              r.op_class = rvd_pkg::CL_C_ADDI16SP; r.dest_reg = 5'd2; r.src1_reg = 5'd2;
              r.immediate = 21'($signed(nz));
            end else begin
              if ({h[12], rlo} == 6'd0) r.status = rvd_pkg::ST_RESERVED;
              r.op_class = rvd_pkg::CL_C_LUI; r.dest_reg = rhi;
              r.immediate = 21'($signed({h[12], rlo, 12'd0}));
            end
          3'd4: begin
            r.dest_reg = rph; r.src1_reg = rph;
            if (h[11:10] == 2'd2) begin
              r.op_class = rvd_pkg::CL_C_ANDI; r.immediate = i6;
            end else if (h[12]) r.status = rvd_pkg::ST_RESERVED;
            else if (h[11:10] == 2'd3) begin
              r.op_class = rvd_pkg::CL_C_SUB + {4'd0, h[6:5]}; r.src2_reg = rpl;
            end else begin
              r.op_class = rvd_pkg::CL_C_SRLI + {5'd0, h[10]}; r.immediate = {16'd0, rlo};
            end
          end
          default: begin
            r.op_class = h[13] ? rvd_pkg::CL_C_BNEZ : rvd_pkg::CL_C_BEQZ;
            r.src1_reg = rph; tgt = 1;
            r.immediate = 21'($signed({h[12], h[6:5], h[2], h[11:10], h[4:3], 1'b0}));
          end
        endcase
      end else if (h[1:0] == 2'd2) begin
        case (h[15:13])
          3'd0: begin
            if (h[12]) r.status = rvd_pkg::ST_RESERVED;
            r.op_class = rvd_pkg::CL_C_SLLI; r.dest_reg = rhi; r.src1_reg = rhi;
            r.immediate = {16'd0, rlo};
          end
          3'd1: begin
            r.op_class = rvd_pkg::CL_C_FLDSP; r.dest_reg = rhi; r.src1_reg = 5'd2;
            r.immediate = {12'd0, h[4:2], h[12], h[6:5], 3'b000};
          end
          3'd2, 3'd3: begin
            if (!h[13] && rhi == 5'd0) r.status = rvd_pkg::ST_RESERVED;
            r.op_class = h[13] ? rvd_pkg::CL_C_FLWSP : rvd_pkg::CL_C_LWSP;
            r.dest_reg = rhi; r.src1_reg = 5'd2;
            r.immediate = {13'd0, h[3:2], h[12], h[6:4], 2'b00};
          end
          3'd4:
            if (rlo == 5'd0) begin
              if (!h[12]) begin
                if (rhi == 5'd0) r.status = rvd_pkg::ST_RESERVED;
                r.op_class = rvd_pkg::CL_C_JR; r.src1_reg = rhi;
              end else if (rhi == 5'd0) r.op_class = rvd_pkg::CL_C_EBREAK;
              else begin
                r.op_class = rvd_pkg::CL_C_JALR; r.dest_reg = 5'd1; r.src1_reg = rhi;
              end
            end else if (!h[12]) begin
              r.op_class = rvd_pkg::CL_C_MV; r.dest_reg = rhi; r.src2_reg = rlo;
            end else begin
              r.op_class = rvd_pkg::CL_C_ADD; r.dest_reg = rhi; r.src1_reg = rhi;
              r.src2_reg = rlo;
            end
          3'd5: begin
            r.op_class = rvd_pkg::CL_C_FSDSP; r.src1_reg = 5'd2; r.src2_reg = rlo;
            r.immediate = {12'd0, h[9:7], h[12:10], 3'b000};
          end
          default: begin
            r.op_class = h[13] ? rvd_pkg::CL_C_FSWSP : rvd_pkg::CL_C_SWSP;
            r.src1_reg = 5'd2; r.src2_reg = rlo;
            r.immediate = {13'd0, h[8:7], h[12:9], 2'b00};
          end
        endcase
      end else r.status = rvd_pkg::ST_UNKNOWN;
    end
    if (tgt) r.target = pc + {{11{r.immediate[20]}}, r.immediate};
    // Error status wipes the whole decode
    if (r.status != rvd_pkg::ST_OK) begin
      r.op_class = rvd_pkg::CL_NONE; r.dest_reg = '0; r.src1_reg = '0; r.src2_reg = '0;
      r.immediate = '0; r.target = '0; r.funct3_field = '0; r.funct7_field = '0;
    end
    return r;
  endfunction

  // Note an accepted parcel; queue a decoded word when an instruction completes
  function void note_parcel(logic [15:0] parcel);
    decoded_word_t r;
    if (half_held) begin
      r = decode_word({parcel, low_half}, 0);
      half_held = 0;
      pc += 32'd4;
      pending_words.push_back(r);
    end else if (parcel[1:0] == 2'b11) begin
      low_half = parcel;
      half_held = 1;
    end else begin
      r = decode_word({16'd0, parcel}, 1);
      pc += 32'd2;
      pending_words.push_back(r);
    end
  endfunction

  // Compare a received word with the oldest expectation
  function void check_word(decoded_word_t got);
    decoded_word_t e;
    if (pending_words.size() == 0) begin
      $error("unexpected word pc=%h", got.inst_pc);
      failures++;
      return;
    end
    e = pending_words.pop_front();
    if (got.inst_pc !== e.inst_pc) begin
      $error("inst_pc exp %h got %h", e.inst_pc, got.inst_pc); failures++; end
    if (got.inst_bits !== e.inst_bits) begin
      $error("inst_bits exp %h got %h", e.inst_bits, got.inst_bits); failures++; end
    if (got.compressed !== e.compressed) begin
      $error("compressed exp %b got %b", e.compressed, got.compressed); failures++; end
    if (got.op_class !== e.op_class) begin
      $error("op_class exp %0d got %0d", e.op_class, got.op_class); failures++; end
    if (got.dest_reg !== e.dest_reg) begin
      $error("dest_reg exp %0d got %0d", e.dest_reg, got.dest_reg); failures++; end
    if (got.src1_reg !== e.src1_reg) begin
      $error("src1_reg exp %0d got %0d", e.src1_reg, got.src1_reg); failures++; end
    if (got.src2_reg !== e.src2_reg) begin
      $error("src2_reg exp %0d got %0d", e.src2_reg, got.src2_reg); failures++; end
    if (got.immediate !== e.immediate) begin
      $error("immediate exp %h got %h", e.immediate, got.immediate); failures++; end
    if (got.target !== e.target) begin
      $error("target exp %h got %h", e.target, got.target); failures++; end
    if (got.funct3_field !== e.funct3_field) begin
      $error("funct3_field exp %0d got %0d", e.funct3_field, got.funct3_field);
      failures++;
    end
    if (got.funct7_field !== e.funct7_field) begin
      $error("funct7_field exp %0d got %0d", e.funct7_field, got.funct7_field);
      failures++;
    end
    if (got.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, got.status); failures++; end
  endfunction
endclass

module testbench;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;

  decode_scoreboard scoreboard;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  localparam int QUIET_LIMIT = 2000;

  rv32ic_instruction_decoder_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Send one parcel, idling beforehand at the current rate
  task automatic send_parcel(input logic [15:0] parcel);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= parcel;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scoreboard.note_parcel(parcel);
    @(negedge clk);
  endtask

  // Random well-formed compressed parcel (low bits not 11)
  function automatic logic [15:0] rand_compressed();
    logic [15:0] p;
    p = 16'($urandom);
    p[1:0] = 2'($urandom_range(2));
    return p;
  endfunction

  // Random full-width instruction, mostly with known opcodes
  task automatic send_full(input bit any_opcode);
    logic [31:0] w;
    logic [6:0] opcodes[8];
    opcodes = '{rvd_pkg::OPC_OP, rvd_pkg::OPC_OPIMM, rvd_pkg::OPC_LOAD,
                rvd_pkg::OPC_JALR, rvd_pkg::OPC_STORE, rvd_pkg::OPC_JAL,
                rvd_pkg::OPC_BRANCH, rvd_pkg::OPC_SYSTEM};
    w = $urandom;
    if (!any_opcode) w[6:0] = opcodes[$urandom_range(7)];
    w[1:0] = 2'b11;
    send_parcel(w[15:0]);
    send_parcel(w[31:16]);
  endtask

  task automatic random_phase(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_full($urandom_range(9) == 0);
        default: send_parcel(rand_compressed());
      endcase
    end
  endtask

  // Receiver: stall at the current rate, check each accepted word
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 0;
    else out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) scoreboard.check_word(out_tdata[150:0]);
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int k;
    scoreboard = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    send_idle_pct = 33;
    recv_idle_pct = 60;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes and special cases
    send_parcel(16'h0000);          // all-zero illegal
    send_parcel(16'hffff); send_parcel(16'hffff); // full word of ones, unknown
    send_parcel(16'h0001);          // c.nop
    send_parcel(16'h0000 | 16'h0020); // c.addi4spn
    send_parcel(16'h0004);          // c.addi4spn zero immediate, reserved
    send_parcel(16'h8000);          // quadrant 0 funct3 100, reserved
    send_parcel(16'h6101);          // c.addi16sp zero immediate
    send_parcel(16'h6081);          // c.lui zero immediate
    send_parcel(16'h9005);          // c.srli shamt bit 5 set
    send_parcel(16'h9c01);          // bit-12 arithmetic group
    send_parcel(16'h1006);          // c.slli shamt bit 5 set
    send_parcel(16'h4002);          // c.lwsp rd 0
    send_parcel(16'h8002);          // c.jr rs1 0
    send_parcel(16'h9002);          // c.ebreak
    send_parcel(16'h9082);          // c.jalr
    send_parcel(16'hbffd);          // c.j negative
    send_parcel(16'h7fff); send_parcel(16'h7fff); // unknown opcode
    send_parcel(16'h006f); send_parcel(16'h8000); // jal negative
    send_parcel(16'h0063); send_parcel(16'h8000); // branch negative
    send_parcel(16'h0073); send_parcel(16'hfff0); // system

    random_phase(365);
    send_idle_pct = 60;
    recv_idle_pct = 33;
    random_phase(365);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(365);
    in_tvalid <= 0;

    k = 0;
    while (scoreboard.pending_words.size() != 0 && k < QUIET_LIMIT) begin
      @(posedge clk);
      k++;
    end
    repeat (10) @(posedge clk);
    if (scoreboard.failures == 0 && scoreboard.pending_words.size() == 0 &&
        !scoreboard.half_held)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
